// File: rtl/tgwmf_pkg.sv
// ----------------------------------------------------------------------------
// tgwmf_pkg
// Shared constants for the tolerance-gated window mean filter.
// ----------------------------------------------------------------------------
package tgwmf_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_SIZE  = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE    = 2'd1;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd3;

   // register reset values
   localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd5;
   localparam logic [10:0] RST_TOLERANCE    = 11'd51;
   localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1920;
   localparam logic [12:0] RST_FRAME_HEIGHT = 13'd1080;

   // coordinate range of the result beats
   localparam int COORD_W     = 12;
   localparam int COORD_LIMIT = 4096;

   // one result beat
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [15:0]        sample;
      logic               replaced;
      logic               last;
   } result_type;

endpackage

// File: rtl/tolerance_gated_window_mean_filter_top.sv
// ----------------------------------------------------------------------------
// tolerance_gated_window_mean_filter_top
// Raster-order window mean filter with a tolerance gate on the centre pixel.
// ----------------------------------------------------------------------------
// One pixel beat is taken at a time. Each beat is accepted and its new window
// column is moved out of the line memory into the window memory (line reads
// alternating with window memory writes, then the new sample is written);
// for an interior pixel the window is then summed out of the window memory,
// one entry a cycle, the divider is loaded, the bit-serial divider forms the
// quotient and the tolerance product and decision are made; each result then
// holds until the output side takes it.
// The line and window memories need no clearing pass.
module tolerance_gated_window_mean_filter_top #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_WINDOW   = 11,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] sample
   input  logic        req_tuser,  // [0] frame_start
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [11:0] out_x, [23:12] out_y, [39:24] out_sample
   output logic        rsp_tuser,  // [0] replaced
   output logic        rsp_tlast,  // last_of_item
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int RMAX  = (MAX_WINDOW - 1) / 2;
   localparam int LINES = 2 * RMAX;
   localparam int WDIM  = 2 * RMAX + 1;
   localparam int WMAX  = (MAX_WIDTH < tgwmf_pkg::COORD_LIMIT) ? MAX_WIDTH
                                                               : tgwmf_pkg::COORD_LIMIT;
   localparam int SLW   = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int LAW   = $clog2(LINES * MAX_WIDTH);
   localparam int WAW   = $clog2(WDIM * WDIM);
   localparam int CW    = $clog2(WDIM);
   localparam int RW    = $clog2(RMAX + 1);
   localparam int CNTW  = $clog2(WDIM * WDIM);
   localparam int SUMW  = SAMPLE_WIDTH + CNTW;
   localparam int DCW   = $clog2(SUMW);
   localparam int PW    = SAMPLE_WIDTH + 11;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LREAD  = 4'd1;
   localparam logic [3:0] ST_LWRITE = 4'd2;
   localparam logic [3:0] ST_LFIN   = 4'd3;
   localparam logic [3:0] ST_SUM    = 4'd4;
   localparam logic [3:0] ST_SDRAIN = 4'd5;
   localparam logic [3:0] ST_DLOAD  = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_MUL    = 4'd8;
   localparam logic [3:0] ST_DEC    = 4'd9;
   localparam logic [3:0] ST_EMIT_I = 4'd10;
   localparam logic [3:0] ST_EMIT_B = 4'd11;

   // memories
   logic [SAMPLE_WIDTH-1:0] line_mem [LINES*MAX_WIDTH];
   logic [SAMPLE_WIDTH-1:0] win_mem  [WDIM*WDIM];

   // configuration registers
   logic [3:0]  win_size_ff;
   logic [10:0] tol_cfg_ff;
   logic [12:0] fwidth_ff, fheight_ff;

   // control state
   logic [3:0]       state_ff, state_in;
   logic [11:0]      col_ff, col_in, row_ff, row_in;
   logic [SLW-1:0]   rslot_ff, rslot_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    k_ff, k_in, j_ff, j_in, wcol_ff, wcol_in;
   logic [SLW-1:0]   rdslot_ff, rdslot_in;
   logic             vld_ff, vld_in, ctr_ff, ctr_in;
   logic [DCW-1:0]   dcnt_ff, dcnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item payload registers
   logic [11:0]             x_ff, x_in, y_ff, y_in;
   logic [SLW-1:0]          slot_ff, slot_in;
   logic [SAMPLE_WIDTH-1:0] s_ff, s_in;
   logic [RW-1:0]           r_ff, r_in;
   logic [10:0]             tol_ff, tol_in;
   logic                    inter_ff, inter_in, border_ff, border_in;
   logic [SUMW-1:0]         acc_ff, acc_in, quo_ff, quo_in;
   logic [CNTW:0]           rem_ff, rem_in;
   logic [SAMPLE_WIDTH-1:0] centre_ff, centre_in;
   logic [PW-1:0]           prod_ff, prod_in;
   tgwmf_pkg::result_type   res_ff, res_in;

   // memory ports
   logic [LAW-1:0]          line_raddr, line_waddr;
   logic                    line_we;
   logic [SAMPLE_WIDTH-1:0] line_q, win_q, win_wdata;
   logic [WAW-1:0]          win_raddr, win_waddr;
   logic                    win_we;

   // clamped configuration as used by the next beat
   logic [12:0]    w_c, h_c;
   logic [RW-1:0]  r_c;
   logic [CNTW-1:0] cnt;
   logic [12:0]    c0, r0, c1, r1;
   logic [SLW-1:0] sl0, sl1;
   logic           acc_req;
   logic [CNTW:0]  rsh;
   logic [SAMPLE_WIDTH-1:0] mean, diff;
   logic [PW-11:0] tolv;
   logic           rep;

   assign acc_req    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {res_ff.sample, res_ff.y, res_ff.x};
   assign rsp_tuser  = res_ff.replaced;
   assign rsp_tlast  = res_ff.last;

   // clamp the registers
   always_comb begin
      if (fwidth_ff == 13'd0) w_c = 13'd1;
      else if (fwidth_ff > 13'(WMAX)) w_c = 13'(WMAX);
      else w_c = fwidth_ff;
      if (fheight_ff == 13'd0) h_c = 13'd1;
      else if (fheight_ff > 13'(tgwmf_pkg::COORD_LIMIT)) h_c = 13'(tgwmf_pkg::COORD_LIMIT);
      else h_c = fheight_ff;
      if (win_size_ff[3:1] == 3'd0) r_c = RW'(1);
      else if (32'(win_size_ff[3:1]) > RMAX) r_c = RW'(RMAX);
      else r_c = RW'(win_size_ff[3:1]);
   end

   // neighbour count (2r+1)^2-1
   assign cnt = CNTW'((CNTW'({r_ff, 1'b1}) * CNTW'({r_ff, 1'b1})) - CNTW'(1));

   // pixel position of the incoming beat
   always_comb begin
      c0  = req_tuser ? 13'd0 : {1'b0, col_ff};
      r0  = req_tuser ? 13'd0 : {1'b0, row_ff};
      sl0 = req_tuser ? '0 : rslot_ff;
      if (c0 >= w_c) begin
         c0  = 13'd0;
         r0  = r0 + 13'd1;
         sl0 = (32'(sl0) == LINES - 1) ? '0 : SLW'(sl0 + SLW'(1));
      end
      if (r0 >= h_c) begin
         r0  = 13'd0;
         sl0 = '0;
      end
      // counters after this beat
      c1  = c0 + 13'd1;
      r1  = r0;
      sl1 = sl0;
      if (c1 >= w_c) begin
         c1  = 13'd0;
         r1  = r0 + 13'd1;
         sl1 = (32'(sl0) == LINES - 1) ? '0 : SLW'(sl0 + SLW'(1));
         if (r1 >= h_c) begin
            r1  = 13'd0;
            sl1 = '0;
         end
      end
   end

   // divider step and tolerance; the tolerance can exceed the sample range
   assign rsh  = {rem_ff[CNTW-1:0], quo_ff[SUMW-1]};
   assign mean = SAMPLE_WIDTH'(quo_ff);
   assign tolv = prod_ff[PW-1:10];

   // gate decision
   assign diff = (mean > centre_ff) ? SAMPLE_WIDTH'(mean - centre_ff)
                                    : SAMPLE_WIDTH'(centre_ff - mean);
   assign rep  = ({1'b0, diff} < tolv);

   // memory addresses
   assign line_raddr = LAW'(LAW'(rdslot_ff) * LAW'(MAX_WIDTH)) + LAW'(x_ff);
   assign line_waddr = LAW'(LAW'(slot_ff) * LAW'(MAX_WIDTH)) + LAW'(x_ff);
   assign line_we    = (state_ff == ST_LFIN);
   assign win_raddr  = WAW'(WAW'(wcol_ff) * WAW'(WDIM)) + WAW'(k_ff);
   assign win_waddr  = WAW'(WAW'(ptr_ff) * WAW'(WDIM))
                       + ((state_ff == ST_LFIN) ? WAW'(0) : WAW'(k_ff));
   assign win_we     = (state_ff == ST_LWRITE) || (state_ff == ST_LFIN);
   assign win_wdata  = (state_ff == ST_LFIN) ? s_ff : line_q;

   // line memory
   always_ff @(posedge clock) begin
      if (line_we) line_mem[line_waddr] <= s_ff;
      line_q <= line_mem[line_raddr];
   end

   // window memory
   always_ff @(posedge clock) begin
      if (win_we) win_mem[win_waddr] <= win_wdata;
      win_q <= win_mem[win_raddr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rslot_in     = rslot_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      wcol_in      = wcol_ff;
      rdslot_in    = rdslot_ff;
      vld_in       = 1'b0;
      ctr_in       = 1'b0;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      slot_in      = slot_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      tol_in       = tol_ff;
      inter_in     = inter_ff;
      border_in    = border_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      centre_in    = centre_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;

      // sum pipeline: data from the read issued last cycle
      if (vld_ff) begin
         if (ctr_ff) centre_in = win_q;
         else acc_in = acc_ff + SUMW'(win_q);
      end

      case (state_ff)
         ST_IDLE: begin
            if (acc_req) begin
               x_in      = c0[11:0];
               y_in      = r0[11:0];
               slot_in   = sl0;
               s_in      = req_tdata[SAMPLE_WIDTH-1:0];
               r_in      = r_c;
               tol_in    = tol_cfg_ff;
               inter_in  = (c0 >= 13'({r_c, 1'b0})) && (r0 >= 13'({r_c, 1'b0}));
               border_in = (c0 < 13'(r_c)) || (c0 + 13'(r_c) >= w_c)
                           || (r0 < 13'(r_c)) || (r0 + 13'(r_c) >= h_c);
               col_in    = c1[11:0];
               row_in    = r1[11:0];
               rslot_in  = sl1;
               ptr_in    = (32'(ptr_ff) == WDIM - 1) ? '0 : CW'(ptr_ff + CW'(1));
               k_in      = CW'(1);
               rdslot_in = (sl0 == '0) ? SLW'(LINES - 1) : SLW'(sl0 - SLW'(1));
               state_in  = ST_LREAD;
            end
         end
         ST_LREAD: state_in = ST_LWRITE;
         ST_LWRITE: begin
            rdslot_in = (rdslot_ff == '0) ? SLW'(LINES - 1) : SLW'(rdslot_ff - SLW'(1));
            k_in      = CW'(k_ff + CW'(1));
            state_in  = (32'(k_ff) == LINES) ? ST_LFIN : ST_LREAD;
         end
         ST_LFIN: begin
            k_in    = '0;
            j_in    = '0;
            wcol_in = ptr_ff;
            acc_in  = '0;
            if (inter_ff) state_in = ST_SUM;
            else if (border_ff) begin
               res_in       = '{x: x_ff, y: y_ff, sample: 16'(s_ff), replaced: 1'b0,
                                last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT_B;
            end else state_in = ST_IDLE;
         end
         ST_SUM: begin
            vld_in = 1'b1;
            ctr_in = (k_ff == CW'(r_ff)) && (j_ff == CW'(r_ff));
            if (j_ff == CW'({r_ff, 1'b0})) begin
               j_in    = '0;
               wcol_in = ptr_ff;
               k_in    = CW'(k_ff + CW'(1));
               if (k_ff == CW'({r_ff, 1'b0})) state_in = ST_SDRAIN;
            end else begin
               j_in    = CW'(j_ff + CW'(1));
               wcol_in = (wcol_ff == '0) ? CW'(WDIM - 1) : CW'(wcol_ff - CW'(1));
            end
         end
         ST_SDRAIN: state_in = ST_DLOAD;
         ST_DLOAD: begin
            quo_in   = acc_ff;
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (rsh >= (CNTW+1)'(cnt)) begin
               rem_in = rsh - (CNTW+1)'(cnt);
               quo_in = {quo_ff[SUMW-2:0], 1'b1};
            end else begin
               rem_in = rsh;
               quo_in = {quo_ff[SUMW-2:0], 1'b0};
            end
            dcnt_in = DCW'(dcnt_ff + DCW'(1));
            if (32'(dcnt_ff) == SUMW - 1) state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PW'(mean) * PW'(tol_ff);
            state_in = ST_DEC;
         end
         ST_DEC: begin
            res_in = '{x: 12'(x_ff - 12'(r_ff)), y: 12'(y_ff - 12'(r_ff)),
                       sample: 16'(rep ? mean : centre_ff), replaced: rep,
                       last: !border_ff};
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_I;
         end
         ST_EMIT_I: begin
            if (rsp_tready) begin
               if (border_ff) begin
                  res_in   = '{x: x_ff, y: y_ff, sample: 16'(s_ff), replaced: 1'b0,
                               last: 1'b1};
                  state_in = ST_EMIT_B;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_EMIT_B: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rslot_ff     <= '0;
         ptr_ff       <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         wcol_ff      <= '0;
         rdslot_ff    <= '0;
         vld_ff       <= 1'b0;
         ctr_ff       <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rslot_ff     <= rslot_in;
         ptr_ff       <= ptr_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         wcol_ff      <= wcol_in;
         rdslot_ff    <= rdslot_in;
         vld_ff       <= vld_in;
         ctr_ff       <= ctr_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      slot_ff   <= slot_in;
      s_ff      <= s_in;
      r_ff      <= r_in;
      tol_ff    <= tol_in;
      inter_ff  <= inter_in;
      border_ff <= border_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      centre_ff <= centre_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= tgwmf_pkg::RST_WINDOW_SIZE;
         tol_cfg_ff  <= tgwmf_pkg::RST_TOLERANCE;
         fwidth_ff   <= tgwmf_pkg::RST_FRAME_WIDTH;
         fheight_ff  <= tgwmf_pkg::RST_FRAME_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tgwmf_pkg::CSR_WINDOW_SIZE:  win_size_ff <= csr_data[3:0];
            tgwmf_pkg::CSR_TOLERANCE:    tol_cfg_ff  <= csr_data[10:0];
            tgwmf_pkg::CSR_FRAME_WIDTH:  fwidth_ff   <= csr_data;
            tgwmf_pkg::CSR_FRAME_HEIGHT: fheight_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // one beat in flight: no input taken while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input taken while a result is pending");

   // an accepted beat always starts the column load
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LREAD))
      else $error("accepted beat did not start the column load");

   // window scan stays inside the active window
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> ((k_ff <= CW'({r_ff, 1'b0})) && (j_ff <= CW'({r_ff, 1'b0}))))
      else $error("window scan out of range");

   // a replaced value only comes from the interior result
   a_rep_interior: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (state_ff == ST_EMIT_I))
      else $error("replaced flag on a border result");

endmodule
